[sv/rfrm_pkg.sv]
// Shared constants, types and codes for the reply frame receiver and matcher.
package rfrm_pkg;

    localparam int WIN_LEN = 20;
    localparam int CRC_LEN = 18;
    localparam int IDX_W   = $clog2(WIN_LEN + 1);

    typedef logic [7:0]              byte_t;
    typedef byte_t [WIN_LEN-1:0]     win_t;
    typedef logic [IDX_W-1:0]        idx_t;

    // Window write controls from the sequencer
    typedef struct packed {
        logic  wr_en;
        idx_t  wr_idx;
        byte_t wr_data;
        logic  slide;
    } win_ctrl_t;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [1:0] REG_REPLY_WINDOW = 2'd0;
    localparam logic [1:0] REG_GAP_LIMIT    = 2'd1;
    localparam logic [1:0] REG_FRESH_AGE    = 2'd2;

    localparam logic [15:0] RST_REPLY_WINDOW = 16'd200;
    localparam logic [15:0] RST_GAP_LIMIT    = 16'd50;
    localparam logic [15:0] RST_FRESH_AGE    = 16'd500;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_ACCEPT   = 3'd1;
    localparam logic [2:0] EV_REJECT   = 3'd2;
    localparam logic [2:0] EV_CRC_BAD  = 3'd3;
    localparam logic [2:0] EV_ECHO     = 3'd4;
    localparam logic [2:0] EV_GAP      = 3'd5;

    localparam int RJ_NOT_AWAITING = 0;
    localparam int RJ_SESSION      = 1;
    localparam int RJ_SEQ          = 2;
    localparam int RJ_DEMAND       = 3;
    localparam int RJ_LATE         = 4;
    localparam int RJ_RESERVED     = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam byte_t HDR_SYNC0     = 8'hA5;
    localparam byte_t HDR_SYNC1     = 8'h5A;
    localparam byte_t HDR_VERSION   = 8'h01;
    localparam byte_t TYPE_REQUEST  = 8'h01;
    localparam byte_t TYPE_REPLY    = 8'h02;
    localparam byte_t FLAG_RESERVED = 8'hF8;

endpackage

[sv/rfrm_if.sv]
// Valid/ready channel interfaces for request/byte words and result words.
interface rfrm_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [31:0] req_session;
    logic [15:0] req_seq;
    logic [7:0]  req_demand;

    modport source (output valid, opcode, rx_byte, now_ms, req_session, req_seq, req_demand,
                     input ready);
    modport sink   (input valid, opcode, rx_byte, now_ms, req_session, req_seq, req_demand,
                     output ready);
endinterface

interface rfrm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [5:0] reject_mask;
    logic [7:0] reply_flags;
    logic       unit_ready;
    logic [7:0] alarm_code;
    logic [7:0] speed_feedback;
    logic [7:0] current_feedback;

    modport source (output valid, event_res, reject_mask, reply_flags, unit_ready,
                     alarm_code, speed_feedback, current_feedback,
                     input ready);
    modport sink   (input valid, event_res, reject_mask, reply_flags, unit_ready,
                     alarm_code, speed_feedback, current_feedback,
                     output ready);
endinterface

[sv/reply_frame_receiver_matcher_top.sv]
// Top level: sequencer, gap check, reply matching and result register.
//
// Each accepted word gives exactly one result word. A request word or a byte
// that does not complete the 20-byte window goes from idle to finish to idle.
// A byte that completes the window goes through the CRC state, where the CRC
// unit walks the 18 protected bytes one per cycle; the finish state then
// checks the header, CRC and match fields and commits the result. The result
// sits in an output register, so the next word is taken while it waits; a
// word is only finished once that register is free. Configuration writes are
// taken at any time and are meant for when the block is idle.
module reply_frame_receiver_matcher_top import rfrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rfrm_in_if.sink     in_ch,
    rfrm_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CRC    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] reply_window_reg, gap_limit_reg, fresh_age_reg;

    idx_t        fill_reg;
    logic [31:0] last_time_reg;
    logic        awaiting_reg;
    logic [31:0] exp_session_reg;
    logic [15:0] exp_seq_reg;
    byte_t       exp_demand_reg;
    logic [31:0] req_time_reg;

    logic [31:0] now_reg;
    logic        gap_reg;
    logic        full_reg;

    logic        out_valid_reg;
    logic [2:0]  ev_reg;
    logic [5:0]  mask_reg;
    byte_t       flags_reg;
    logic        pready_reg;
    byte_t       alarm_reg, speed_reg, current_reg;

    win_ctrl_t   win_ctrl;
    win_t        wb;
    byte_t       rd_data;
    idx_t        crc_idx;
    logic        crc_last;
    logic [15:0] crc_val;
    logic        crc_start;

    logic        accept;
    logic        gap_now;
    idx_t        wr_idx;
    idx_t        fill_inc;
    logic        out_free;
    logic        commit;

    logic        hdr_ok, crc_ok, is_reply, is_echo, late, fresh, pump;
    logic [31:0] reply_age;
    logic [5:0]  mask;
    logic [2:0]  ev;

    rfrm_window u_window (
        .clk     (clk),
        .ctrl    (win_ctrl),
        .rd_idx  (crc_idx),
        .rd_data (rd_data),
        .bytes   (wb)
    );

    rfrm_crc u_crc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (crc_start),
        .run    (state_reg == ST_CRC),
        .data   (rd_data),
        .rd_idx (crc_idx),
        .last   (crc_last),
        .crc    (crc_val)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign gap_now     = (fill_reg != '0) &&
                         ((in_ch.now_ms - last_time_reg) > {16'h0000, gap_limit_reg});
    assign wr_idx      = gap_now ? idx_t'(0) : fill_reg;
    assign fill_inc    = wr_idx + idx_t'(1);
    assign crc_start   = accept && (in_ch.opcode == OP_BYTE) &&
                         (fill_inc == idx_t'(WIN_LEN));
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign commit      = (state_reg == ST_FINISH) && out_free;

    // Frame checks on the full window
    assign hdr_ok    = (wb[0] == HDR_SYNC0) && (wb[1] == HDR_SYNC1) && (wb[2] == HDR_VERSION);
    assign crc_ok    = ({wb[19], wb[18]} == crc_val);
    assign is_reply  = hdr_ok && crc_ok && (wb[3] == TYPE_REPLY);
    assign is_echo   = hdr_ok && crc_ok && (wb[3] == TYPE_REQUEST);
    assign reply_age = now_reg - req_time_reg;
    assign late      = reply_age > {16'h0000, reply_window_reg};

    always_comb
    begin
        mask                  = '0;
        mask[RJ_NOT_AWAITING] = !awaiting_reg;
        mask[RJ_SESSION]      = ({wb[7], wb[6], wb[5], wb[4]} != exp_session_reg);
        mask[RJ_SEQ]          = ({wb[9], wb[8]} != exp_seq_reg);
        mask[RJ_DEMAND]       = (wb[10] != exp_demand_reg);
        mask[RJ_LATE]         = late;
        mask[RJ_RESERVED]     = ((wb[11] & FLAG_RESERVED) != 8'h00);
    end

    assign fresh = wb[11][1] && ({wb[13], wb[12]} <= fresh_age_reg);
    assign pump  = wb[11][0] && fresh && !wb[11][2] && !wb[14][1] && (wb[17] == 8'h00);

    always_comb
    begin
        ev = gap_reg ? EV_GAP : EV_NONE;
        if (full_reg)
        begin
            if (is_reply)
            begin
                ev = (mask == '0) ? EV_ACCEPT : EV_REJECT;
            end
            else if (hdr_ok && !crc_ok)
            begin
                ev = EV_CRC_BAD;
            end
            else if (is_echo)
            begin
                ev = EV_ECHO;
            end
            else
            begin
                ev = EV_NONE;
            end
        end
    end

    always_comb
    begin
        win_ctrl.wr_en   = accept && (in_ch.opcode == OP_BYTE);
        win_ctrl.wr_idx  = wr_idx;
        win_ctrl.wr_data = in_ch.rx_byte;
        win_ctrl.slide   = commit && full_reg && !is_reply;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = crc_start ? ST_CRC : ST_FINISH;
                end
            end
            ST_CRC:
            begin
                if (crc_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            reply_window_reg <= RST_REPLY_WINDOW;
            gap_limit_reg    <= RST_GAP_LIMIT;
            fresh_age_reg    <= RST_FRESH_AGE;
            fill_reg         <= '0;
            last_time_reg    <= '0;
            awaiting_reg     <= 1'b0;
            exp_session_reg  <= '0;
            exp_seq_reg      <= '0;
            exp_demand_reg   <= '0;
            req_time_reg     <= '0;
            gap_reg          <= 1'b0;
            full_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REPLY_WINDOW: reply_window_reg <= cfg_wdata;
                    REG_GAP_LIMIT:    gap_limit_reg    <= cfg_wdata;
                    REG_FRESH_AGE:    fresh_age_reg    <= cfg_wdata;
                    default:          ;
                endcase
            end

            if (accept)
            begin
                gap_reg  <= gap_now;
                full_reg <= crc_start;
                if (in_ch.opcode == OP_REQUEST)
                begin
                    awaiting_reg    <= 1'b1;
                    exp_session_reg <= in_ch.req_session;
                    exp_seq_reg     <= in_ch.req_seq;
                    exp_demand_reg  <= in_ch.req_demand;
                    req_time_reg    <= in_ch.now_ms;
                    if (gap_now)
                    begin
                        fill_reg <= '0;
                    end
                end
                else
                begin
                    last_time_reg <= in_ch.now_ms;
                    fill_reg      <= fill_inc;
                end
            end

            if (commit && full_reg)
            begin
                if (is_reply)
                begin
                    fill_reg <= '0;
                    if (mask == '0)
                    begin
                        awaiting_reg <= 1'b0;
                    end
                end
                else
                begin
                    fill_reg <= idx_t'(WIN_LEN - 1);
                end
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on commit; the word's time stamp loads on accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= in_ch.now_ms;
        end
        if (commit)
        begin
            ev_reg      <= ev;
            mask_reg    <= (full_reg && is_reply) ? mask : 6'd0;
            flags_reg   <= (full_reg && is_reply) ? wb[11] : 8'h00;
            pready_reg  <= (ev == EV_ACCEPT) && pump;
            alarm_reg   <= (ev == EV_ACCEPT) ? wb[17] : 8'h00;
            speed_reg   <= (ev == EV_ACCEPT) ? wb[15] : 8'h00;
            current_reg <= (ev == EV_ACCEPT) ? wb[16] : 8'h00;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.event_res        = ev_reg;
    assign out_ch.reject_mask      = mask_reg;
    assign out_ch.reply_flags      = flags_reg;
    assign out_ch.unit_ready       = pready_reg;
    assign out_ch.alarm_code       = alarm_reg;
    assign out_ch.speed_feedback   = speed_reg;
    assign out_ch.current_feedback = current_reg;

endmodule

[sv/rfrm_window.sv]
// Twenty-byte receive window: indexed write, slide by one, one indexed read.
module rfrm_window import rfrm_pkg::*;
(
    input  logic      clk,
    input  win_ctrl_t ctrl,
    input  idx_t      rd_idx,
    output byte_t     rd_data,
    output win_t      bytes
);

    win_t win_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.slide)
        begin
            // drop the oldest byte, last entry holds
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
        end
        else if (ctrl.wr_en)
        begin
            win_reg[ctrl.wr_idx] <= ctrl.wr_data;
        end
    end

    assign rd_data = win_reg[rd_idx];
    assign bytes   = win_reg;

endmodule

[sv/rfrm_crc.sv]
// CRC-16/MODBUS unit: one window byte per cycle over the protected bytes.
module rfrm_crc import rfrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        run,
    input  byte_t       data,
    output idx_t        rd_idx,
    output logic        last,
    output logic [15:0] crc
);

    idx_t        cnt_reg;
    logic [15:0] crc_reg;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input byte_t d);
        logic [15:0] c;
        c = c_in ^ {8'h00, d};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else if (start)
        begin
            cnt_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else if (run)
        begin
            cnt_reg <= cnt_reg + idx_t'(1);
            crc_reg <= crc_byte(crc_reg, data);
        end
    end

    assign rd_idx = cnt_reg;
    assign last   = (cnt_reg == idx_t'(CRC_LEN - 1));
    assign crc    = crc_reg;

endmodule
